>>> hw/rtl/csv_tokenizer_with_column_widths_defines.svh
// Assertion macros for the CSV tokenizer.
// Used by the top level, which provides clk_i and rst_ni in scope.
`ifndef CSV_TOKENIZER_WITH_COLUMN_WIDTHS_DEFINES_SVH
`define CSV_TOKENIZER_WITH_COLUMN_WIDTHS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSVT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/csvt_pkg.sv
// Shared types and constants of the CSV tokenizer.
// Used by every module of the block but csvt_ram; depends on nothing.
package csvt_pkg;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_SEPARATOR = 3'd0;
  localparam logic [2:0] REG_ROW_END   = 3'd1;
  localparam logic [2:0] REG_ESCAPE    = 3'd2;
  localparam logic [2:0] REG_QUOTE     = 3'd3;
  localparam logic [2:0] REG_MERGE     = 3'd4;

  localparam logic [7:0] SEPARATOR_RST = 8'd44;
  localparam logic [7:0] ROW_END_RST   = 8'd10;
  localparam logic [7:0] ESCAPE_RST    = 8'd92;
  localparam logic [7:0] QUOTE_RST     = 8'd34;

  // A row end inside quotes is written out as these two bytes.
  localparam logic [7:0] BACKSLASH_BYTE = 8'd92;
  localparam logic [7:0] LETTER_N_BYTE  = 8'd110;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_PW + 1;

  typedef struct packed {
    logic [7:0] separator;
    logic [7:0] row_end_byte;
    logic [7:0] escape_byte;
    logic [7:0] quote_byte;
    logic       merge_separators;
  } csvt_cfg_t;

  // What one input byte asks of the width stage.
  typedef struct packed {
    logic [1:0] n;
    logic       cell_end;
    logic       row_end;
    logic       too_many;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [5:0] column;
  } csvt_op_t;

  // One output word.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        cell_end;
    logic        row_end;
    logic [5:0]  column;
    logic [15:0] column_width;
    logic        too_many_columns;
    logic        last;
  } csvt_res_t;

endpackage

>>> hw/rtl/csv_tokenizer_with_column_widths.sv
// CSV tokenizer with per-column maximum widths: top level.
// Depends on csvt_pkg, csvt_parse, csvt_widths, csvt_fifo and the defines header.
//
// Usage:
//   Input channel: one raw text byte per word on in_byte_i, taken when
//   in_valid_i is high and in_stall_o is low. Output channel: one result
//   word per cycle, taken when out_valid_o is high and out_stall_i is low.
//   A byte gives zero, one or two words; last_o marks the final word of a byte.
//   Path: a taken byte is registered in the width stage, its words are then
//   written into the output queue, and only then offered on the output.
//   Throughput: one byte per cycle while the receiver keeps up; a row end
//   inside quotes gives two words, which leave the port one at a time. The output
//   port and a four-word output queue set the sustained figure.
//   The width table lives in one RAM with a registered read; its read, max and
//   write-back span two stages, with forwarding between back-to-back updates
//   of the same column.
//   Reset clears the parser state and sets the registers to their defaults.
//   The table reads as all zero right after reset through a fill count, so no
//   clearing pass is run and the first byte may be taken in the first cycle.
//   On a receiver stall the queue fills and in_stall_o rises; nothing is lost.
//   The user writes registers over the APB-style port while idle; not enforced.
`include "csv_tokenizer_with_column_widths_defines.svh"

module csv_tokenizer_with_column_widths
  import csvt_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        cell_end_o,
  output logic        row_end_o,
  output logic [5:0]  column_o,
  output logic [15:0] column_width_o,
  output logic        too_many_columns_o,
  output logic        last_o
);

  localparam int CIW  = $clog2(MAX_COLUMNS + 1);
  localparam int OCCW = FIFO_CW + 1;

  csvt_cfg_t              cfg_q;
  logic                   cfg_we;
  logic                   accept, pop;
  csvt_op_t               op;
  logic [LENGTH_BITS-1:0] cell_len;
  logic [CIW-1:0]         col_idx;
  logic [1:0]             push_n;
  csvt_res_t              push0, push1, head;
  logic [FIFO_CW-1:0]     fifo_count;
  logic [OCCW-1:0]        occ;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.separator        <= SEPARATOR_RST;
      cfg_q.row_end_byte     <= ROW_END_RST;
      cfg_q.escape_byte      <= ESCAPE_RST;
      cfg_q.quote_byte       <= QUOTE_RST;
      cfg_q.merge_separators <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_SEPARATOR: cfg_q.separator        <= pwdata[7:0];
        REG_ROW_END:   cfg_q.row_end_byte     <= pwdata[7:0];
        REG_ESCAPE:    cfg_q.escape_byte      <= pwdata[7:0];
        REG_QUOTE:     cfg_q.quote_byte       <= pwdata[7:0];
        REG_MERGE:     cfg_q.merge_separators <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SEPARATOR: prdata = 32'(cfg_q.separator);
      REG_ROW_END:   prdata = 32'(cfg_q.row_end_byte);
      REG_ESCAPE:    prdata = 32'(cfg_q.escape_byte);
      REG_QUOTE:     prdata = 32'(cfg_q.quote_byte);
      REG_MERGE:     prdata = 32'(cfg_q.merge_separators);
      default:       prdata = '0;
    endcase
  end

  // Words in the queue plus words in the width stage; an accepted byte may add
  // two more, so the input stalls once fewer than two slots remain.
  assign occ        = OCCW'(fifo_count) + OCCW'(push_n);
  assign in_stall_o = (occ > OCCW'(FIFO_DEPTH - 2));
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  csvt_parse #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .op_o      (op),
    .cell_len_o(cell_len),
    .col_idx_o (col_idx)
  );

  csvt_widths #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_widths (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (op),
    .cell_len_i(cell_len),
    .col_idx_i (col_idx),
    .push_n_o  (push_n),
    .push0_o   (push0),
    .push1_o   (push1)
  );

  csvt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_n_i(push_n),
    .push0_i (push0),
    .push1_i (push1),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (out_valid_o),
    .count_o (fifo_count)
  );

  assign out_byte_o         = head.out_byte;
  assign byte_valid_o       = head.byte_valid;
  assign cell_end_o         = head.cell_end;
  assign row_end_o          = head.row_end;
  assign column_o           = head.column;
  assign column_width_o     = head.column_width;
  assign too_many_columns_o = head.too_many_columns;
  assign last_o             = head.last;

  `CSVT_ASSERT_IMP(a_queue_no_overflow, push_n != 2'd0, occ <= OCCW'(FIFO_DEPTH),
                   "output queue overflow")
  `CSVT_ASSERT_NXT(a_row_end_resets_column, accept && op.cell_end && op.row_end,
                   col_idx == '0, "column not reset after row end")
  `CSVT_ASSERT_NXT(a_stage_takes_words, accept, push_n == $past(op.n),
                   "width stage lost words of a byte")

endmodule

>>> hw/rtl/csvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module csvt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/csvt_fifo.sv
// Output queue of the CSV tokenizer: takes up to two words a cycle, gives one.
// Depends on csvt_pkg.
module csvt_fifo
  import csvt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_n_i,
  input  csvt_res_t          push0_i,
  input  csvt_res_t          push1_i,
  input  logic               pop_i,
  output csvt_res_t          head_o,
  output logic               valid_o,
  output logic [FIFO_CW-1:0] count_o
);

  csvt_res_t          mem_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FIFO_PW-1:0] wp_next;
  logic [FIFO_CW-1:0] count_q, count_d;

  assign wp_next = wp_q + FIFO_PW'(1);

  always_comb begin
    wp_d    = wp_q + FIFO_PW'(push_n_i);
    rp_d    = pop_i ? rp_q + FIFO_PW'(1) : rp_q;
    count_d = count_q + FIFO_CW'(push_n_i) - FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wp_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wp_next] <= push1_i;
    end
  end

  assign head_o  = mem_q[rp_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

>>> hw/rtl/csvt_parse.sv
// Byte classifier of the CSV tokenizer: quote, escape, cell length and column state.
// Depends on csvt_pkg.
module csvt_parse
  import csvt_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int LENGTH_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  csvt_cfg_t                          cfg_i,
  input  logic                               accept_i,
  input  logic [7:0]                         in_byte_i,
  output csvt_op_t                           op_o,
  output logic [LENGTH_BITS-1:0]             cell_len_o,
  output logic [$clog2(MAX_COLUMNS+1)-1:0]   col_idx_o
);

  localparam int CIW = $clog2(MAX_COLUMNS + 1);
  localparam int CXW = (CIW > 6) ? CIW : 6;

  logic                   inq_q, inq_d;
  logic                   esc_q, esc_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [CIW-1:0]         col_q, col_d;
  logic [LENGTH_BITS:0]   len_sum;
  logic [CXW-1:0]         col_ext;
  logic                   overflow;
  logic                   cend, rend;
  csvt_op_t               op;

  assign col_ext  = CXW'(col_q);
  assign overflow = (col_q >= CIW'(MAX_COLUMNS));

  always_comb begin
    op          = '0;
    op.column   = col_ext[5:0];
    op.too_many = overflow;
    op.byte0    = in_byte_i;
    inq_d       = inq_q;
    esc_d       = esc_q;
    cend        = 1'b0;
    rend        = 1'b0;

    if (esc_q) begin
      esc_d = 1'b0;
      op.n  = 2'd1;
    end else if (in_byte_i == cfg_i.quote_byte) begin
      inq_d = !inq_q;
      op.n  = 2'd1;
    end else if (!inq_q && in_byte_i == cfg_i.separator) begin
      // In merge mode a separator on an empty cell is dropped entirely.
      if (!cfg_i.merge_separators || len_q != '0) begin
        cend = 1'b1;
      end
    end else if (in_byte_i == cfg_i.row_end_byte) begin
      if (!inq_q) begin
        cend = 1'b1;
        rend = 1'b1;
      end else begin
        op.n     = 2'd2;
        op.byte0 = BACKSLASH_BYTE;
        op.byte1 = LETTER_N_BYTE;
      end
    end else if (in_byte_i == cfg_i.escape_byte) begin
      esc_d = 1'b1;
      op.n  = 2'd1;
    end else begin
      op.n = 2'd1;
    end

    len_sum = {1'b0, len_q} + (LENGTH_BITS + 1)'(op.n);

    if (cend) begin
      op.n        = 2'd1;
      op.cell_end = 1'b1;
      op.row_end  = rend;
      op.byte0    = '0;
      len_d       = '0;
      if (rend) begin
        col_d = '0;
      end else if (!overflow) begin
        col_d = col_q + CIW'(1);
      end else begin
        col_d = col_q;
      end
    end else begin
      len_d = len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];
      col_d = col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_q <= 1'b0;
      esc_q <= 1'b0;
      len_q <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      inq_q <= inq_d;
      esc_q <= esc_d;
      len_q <= len_d;
      col_q <= col_d;
    end
  end

  assign op_o       = op;
  assign cell_len_o = len_q;
  assign col_idx_o  = col_q;

endmodule

>>> hw/rtl/csvt_widths.sv
// Column width stage: reads the width table, takes the maximum, writes it back
// and forms the output words. Depends on csvt_pkg and csvt_ram.
module csvt_widths
  import csvt_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int LENGTH_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  csvt_op_t                         op_i,
  input  logic [LENGTH_BITS-1:0]           cell_len_i,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0] col_idx_i,
  output logic [1:0]                       push_n_o,
  output csvt_res_t                        push0_o,
  output csvt_res_t                        push1_o
);

  localparam int CIW = $clog2(MAX_COLUMNS + 1);
  localparam int AW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int WXW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [1:0]             n_q;
  csvt_op_t               op_q;
  logic [LENGTH_BITS-1:0] len_q;
  logic [CIW-1:0]         col_q;
  logic [CIW-1:0]         fill_q, fill_d;
  logic                   fwd_vld_q;
  logic [AW-1:0]          fwd_addr_q;
  logic [LENGTH_BITS-1:0] fwd_data_q;

  logic [LENGTH_BITS-1:0] rdata, stored, width;
  logic [WXW-1:0]         width_ext;
  logic [AW-1:0]          waddr;
  logic                   we, fwd_hit;

  assign waddr = col_q[AW-1:0];
  assign we    = (n_q != 2'd0) && op_q.cell_end && !op_q.too_many;

  csvt_ram #(
    .WIDTH(LENGTH_BITS),
    .DEPTH(MAX_COLUMNS)
  ) u_width_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(width),
    .raddr_i(col_idx_i[AW-1:0]),
    .rdata_o(rdata)
  );

  // Written columns always form a prefix of the table, so entries at or above
  // the fill count have never been written and read as zero. A write in the
  // previous cycle is not yet visible in the read data and is forwarded.
  assign fwd_hit = fwd_vld_q && (fwd_addr_q == waddr);

  always_comb begin
    if (fwd_hit) begin
      stored = fwd_data_q;
    end else if (col_q < fill_q) begin
      stored = rdata;
    end else begin
      stored = '0;
    end
    if (op_q.too_many || stored <= len_q) begin
      width = len_q;
    end else begin
      width = stored;
    end
    fill_d = (we && col_q == fill_q) ? fill_q + CIW'(1) : fill_q;
  end

  assign width_ext = WXW'(width);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= 2'd0;
      fill_q    <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      n_q       <= accept_i ? op_i.n : 2'd0;
      fill_q    <= fill_d;
      fwd_vld_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q  <= op_i;
      len_q <= cell_len_i;
      col_q <= col_idx_i;
    end
    if (we) begin
      fwd_addr_q <= waddr;
      fwd_data_q <= width;
    end
  end

  always_comb begin
    push0_o                  = '0;
    push0_o.column           = op_q.column;
    push0_o.too_many_columns = op_q.too_many;
    push1_o                  = push0_o;
    if (op_q.cell_end) begin
      push0_o.cell_end     = 1'b1;
      push0_o.row_end      = op_q.row_end;
      push0_o.column_width = width_ext[15:0];
    end else begin
      push0_o.out_byte   = op_q.byte0;
      push0_o.byte_valid = 1'b1;
    end
    push0_o.last       = (n_q != 2'd2);
    push1_o.out_byte   = op_q.byte1;
    push1_o.byte_valid = 1'b1;
    push1_o.last       = 1'b1;
  end

  assign push_n_o = n_q;

endmodule
